[hw/rtl/lcd_shadow_framebuffer_flusher_defines.svh]
// Assertion macros used by the checker file of the shadow framebuffer flusher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LCD_SHADOW_FRAMEBUFFER_FLUSHER_DEFINES_SVH
`define LCD_SHADOW_FRAMEBUFFER_FLUSHER_DEFINES_SVH

// Antecedent holds at one edge, consequent must hold at the next edge.
`define LSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd shadow framebuffer flusher: check failed");

// Antecedent and consequent are checked at the same edge.
`define LSF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd shadow framebuffer flusher: check failed");

`endif

[hw/rtl/lsf_pkg.sv]
// Types and constants of the LCD shadow framebuffer flusher.
// No dependencies; the flusher and its checker import this package.
package lsf_pkg;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_INIT  = 2'd3
    } lsf_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR0,
        ST_ADDR1,
        ST_DATA_HI,
        ST_DATA_LO,
        ST_INIT,
        ST_SWEEP,
        ST_SET_RD,
        ST_SET_WR
    } lsf_state_t;

    localparam int          BANK_BITS    = 16;
    localparam logic [15:0] PIXEL_MSB    = 16'h8000;
    localparam logic [7:0]  ADDR_CMD     = 8'h80;
    localparam logic [7:0]  LOWER_HALF_H = 8'h08;
    localparam logic [5:0]  HALF_ROWS    = 6'd32;

    localparam int          INIT_LEN = 6;
    localparam int          INIT_W   = $clog2(INIT_LEN);
    localparam logic [7:0]  INIT_BYTES [INIT_LEN] = '{
        8'h30, 8'h30 | 8'h04, 8'h30 | 8'h04 | 8'h02, 8'h0c, 8'h06, 8'h01
    };
    localparam logic [7:0]  INIT_LAST_BYTE = 8'h01;

endpackage

[hw/rtl/lsf_if.sv]
// Handshake channels of the LCD shadow framebuffer flusher: commands in, bytes out.
// Standalone; the field widths are fixed by the command and byte formats.
interface lsf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [6:0] x;
    logic [5:0] y;
    logic       value;

    modport source (output valid, output command, output x, output y, output value,
                    input ready);
    modport sink   (input valid, input command, input x, input y, input value,
                    output ready);
endinterface

interface lsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_command;
    logic       last;

    modport source (output valid, output out_byte, output is_command, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_command, input last,
                    output ready);
endinterface

[hw/rtl/lcd_shadow_framebuffer_flusher.sv]
// Channel | Role   | Beat contents
// cmd     | sink   | command, x, y, value
// lcd     | source | out_byte, is_command, last
//
// Flush row: two address command bytes, then a high and a low data byte per bank,
// one byte per cycle through the output register while lcd is not stalled; the
// next bank is fetched while the previous low byte goes out. Init sends INIT_BYTES.
// Set pixel: a read and a write of the target bank on a row written since the last
// fill, otherwise a sweep that writes every bank of the row. Reset clears one valid
// bit per row and the fill level; the RAM gets no clearing pass. A stalled lcd beat
// holds the sequencer; cmd is ready only between items.
module lcd_shadow_framebuffer_flusher
    import lsf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lsf_cmd_if.sink    cmd,
    lsf_byte_if.source lcd
);

    localparam int ROW_BANKS = (SCREEN_WIDTH + 15) / 16;
    localparam int BANK_W    = (ROW_BANKS > 1) ? $clog2(ROW_BANKS) : 1;
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
    localparam int ADDR_W    = ROW_W + BANK_W;
    localparam int RAM_DEPTH = SCREEN_HEIGHT * (1 << BANK_W);

    localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(ROW_BANKS - 1);

    lsf_state_t state_reg, state_next;

    logic [SCREEN_HEIGHT-1:0] row_valid_reg, row_valid_next;
    logic                     fill_val_reg, fill_val_next;
    logic [5:0]               y_reg, y_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [BANK_W-1:0]        tgt_reg, tgt_next;
    logic [15:0]              mask_reg, mask_next;
    logic                     value_reg, value_next;
    logic [BANK_W-1:0]        bank_cnt_reg, bank_cnt_next;
    logic [INIT_W-1:0]        init_cnt_reg, init_cnt_next;

    logic       lcd_valid_reg, lcd_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       is_cmd_reg, is_cmd_next;
    logic       last_reg, last_next;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [BANK_BITS-1:0] ram_wdata, ram_rdata;

    logic                 adv;
    logic                 accept;
    logic                 x_out, y_out;
    logic [ROW_W-1:0]     cmd_row;
    logic [BANK_BITS-1:0] fill_word;
    logic [BANK_BITS-1:0] bank_data;
    logic                 upper_half;

    lsf_ram #(
        .WIDTH (BANK_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_banks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register may load when it is empty or its beat is taken.
    assign adv       = !lcd_valid_reg || lcd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    assign x_out      = (9'(cmd.x) >= 9'(SCREEN_WIDTH));
    assign y_out      = (7'(cmd.y) >= 7'(SCREEN_HEIGHT));
    assign cmd_row    = ROW_W'(cmd.y);
    assign fill_word  = {BANK_BITS{fill_val_reg}};
    // A row not written since the last fill holds the fill level everywhere.
    assign bank_data  = row_valid_reg[row_reg] ? ram_rdata : fill_word;
    assign upper_half = (y_reg >= HALF_ROWS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (lsf_cmd_t'(cmd.command))
                        CMD_SET:
                        begin
                            if (x_out || y_out)
                                state_next = ST_IDLE;
                            else if (row_valid_reg[cmd_row])
                                state_next = ST_SET_RD;
                            else
                                state_next = ST_SWEEP;
                        end
                        CMD_FILL:  state_next = ST_IDLE;
                        CMD_FLUSH: state_next = y_out ? ST_IDLE : ST_ADDR0;
                        CMD_INIT:  state_next = ST_INIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADDR0:   if (adv) state_next = ST_ADDR1;
            ST_ADDR1:   if (adv) state_next = ST_DATA_HI;
            ST_DATA_HI: if (adv) state_next = ST_DATA_LO;
            ST_DATA_LO:
            begin
                if (adv)
                    state_next = (bank_cnt_reg == LAST_BANK) ? ST_IDLE : ST_DATA_HI;
            end
            ST_INIT:
            begin
                if (adv && (init_cnt_reg == INIT_W'(INIT_LEN - 1)))
                    state_next = ST_IDLE;
            end
            ST_SWEEP:   if (bank_cnt_reg == LAST_BANK) state_next = ST_IDLE;
            ST_SET_RD:  state_next = ST_SET_WR;
            ST_SET_WR:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        fill_val_next  = fill_val_reg;
        y_next         = y_reg;
        row_next       = row_reg;
        tgt_next       = tgt_reg;
        mask_next      = mask_reg;
        value_next     = value_reg;
        bank_cnt_next  = bank_cnt_reg;
        init_cnt_next  = init_cnt_reg;

        lcd_valid_next = lcd_valid_reg && !lcd.ready;
        byte_next      = byte_reg;
        is_cmd_next    = is_cmd_reg;
        last_next      = last_reg;

        ram_we    = 1'b0;
        ram_waddr = {row_reg, bank_cnt_reg};
        ram_wdata = fill_word;
        ram_re    = 1'b0;
        ram_raddr = {row_reg, bank_cnt_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    y_next        = cmd.y;
                    row_next      = cmd_row;
                    tgt_next      = BANK_W'(cmd.x[6:4]);
                    mask_next     = PIXEL_MSB >> cmd.x[3:0];
                    value_next    = cmd.value;
                    bank_cnt_next = '0;
                    init_cnt_next = '0;
                    if (cmd.command == CMD_FILL)
                    begin
                        row_valid_next = '0;
                        fill_val_next  = cmd.value;
                    end
                end
            end
            ST_ADDR0:
            begin
                if (adv)
                begin
                    lcd_valid_next = 1'b1;
                    byte_next      = ADDR_CMD | 8'(upper_half ? (y_reg - HALF_ROWS) : y_reg);
                    is_cmd_next    = 1'b1;
                    last_next      = 1'b0;
                end
            end
            ST_ADDR1:
            begin
                if (adv)
                begin
                    lcd_valid_next = 1'b1;
                    byte_next      = upper_half ? (ADDR_CMD | LOWER_HALF_H) : ADDR_CMD;
                    is_cmd_next    = 1'b1;
                    last_next      = 1'b0;
                    ram_re         = 1'b1;
                    ram_raddr      = {row_reg, {BANK_W{1'b0}}};
                end
            end
            ST_DATA_HI:
            begin
                if (adv)
                begin
                    lcd_valid_next = 1'b1;
                    byte_next      = bank_data[15:8];
                    is_cmd_next    = 1'b0;
                    last_next      = 1'b0;
                end
            end
            ST_DATA_LO:
            begin
                if (adv)
                begin
                    lcd_valid_next = 1'b1;
                    byte_next      = bank_data[7:0];
                    is_cmd_next    = 1'b0;
                    last_next      = (bank_cnt_reg == LAST_BANK);
                    if (bank_cnt_reg != LAST_BANK)
                    begin
                        // Fetch the next bank while its predecessor's low byte goes out.
                        bank_cnt_next = bank_cnt_reg + 1'b1;
                        ram_re        = 1'b1;
                        ram_raddr     = {row_reg, bank_cnt_reg + 1'b1};
                    end
                end
            end
            ST_INIT:
            begin
                if (adv)
                begin
                    lcd_valid_next = 1'b1;
                    byte_next      = INIT_BYTES[init_cnt_reg];
                    is_cmd_next    = 1'b1;
                    last_next      = (init_cnt_reg == INIT_W'(INIT_LEN - 1));
                    init_cnt_next  = init_cnt_reg + 1'b1;
                end
            end
            ST_SWEEP:
            begin
                // Materialize the fill level across the row, with the pixel applied.
                ram_we = 1'b1;
                if (bank_cnt_reg == tgt_reg)
                    ram_wdata = value_reg ? (fill_word | mask_reg) : (fill_word & ~mask_reg);
                bank_cnt_next = bank_cnt_reg + 1'b1;
                if (bank_cnt_reg == LAST_BANK)
                    row_valid_next[row_reg] = 1'b1;
            end
            ST_SET_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = {row_reg, tgt_reg};
            end
            ST_SET_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {row_reg, tgt_reg};
                ram_wdata = value_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            fill_val_reg  <= 1'b0;
            lcd_valid_reg <= 1'b0;
            bank_cnt_reg  <= '0;
            init_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            fill_val_reg  <= fill_val_next;
            lcd_valid_reg <= lcd_valid_next;
            bank_cnt_reg  <= bank_cnt_next;
            init_cnt_reg  <= init_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        row_reg    <= row_next;
        tgt_reg    <= tgt_next;
        mask_reg   <= mask_next;
        value_reg  <= value_next;
        byte_reg   <= byte_next;
        is_cmd_reg <= is_cmd_next;
        last_reg   <= last_next;
    end

    assign lcd.valid      = lcd_valid_reg;
    assign lcd.out_byte   = byte_reg;
    assign lcd.is_command = is_cmd_reg;
    assign lcd.last       = last_reg;

endmodule

[hw/rtl/lsf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lsf_checker.sv]
// Port-level checks of the LCD shadow framebuffer flusher, bound to its top level.
// Depends on lsf_pkg and the assertion macros header.
`include "lcd_shadow_framebuffer_flusher_defines.svh"

module lsf_checker
    import lsf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd_command,
    input logic       lcd_valid,
    input logic       lcd_ready,
    input logic [7:0] lcd_out_byte,
    input logic       lcd_is_command,
    input logic       lcd_last
);

    logic cmd_beat;
    assign cmd_beat = cmd_valid && cmd_ready;

    // A stalled byte beat stays offered and unchanged.
    `LSF_ASSERT_NEXT(a_lcd_hold, lcd_valid && !lcd_ready,
        lcd_valid && $stable(lcd_out_byte) && $stable(lcd_is_command) && $stable(lcd_last))

    // The init sequence always occupies the block past its accepting edge.
    `LSF_ASSERT_NEXT(a_init_busy, cmd_beat && (cmd_command == CMD_INIT), !cmd_ready)

    // Set pixel and fill never start a new byte beat.
    `LSF_ASSERT_NEXT(a_quiet_cmds,
        cmd_beat && ((cmd_command == CMD_SET) || (cmd_command == CMD_FILL)),
        !$rose(lcd_valid))

    // Only the init sequence ends on a command byte, and it ends on the same one.
    `LSF_ASSERT_SAME(a_init_tail, lcd_valid && lcd_last && lcd_is_command,
        lcd_out_byte == INIT_LAST_BYTE)

endmodule

bind lcd_shadow_framebuffer_flusher lsf_checker u_lsf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_command    (cmd.command),
    .lcd_valid      (lcd.valid),
    .lcd_ready      (lcd.ready),
    .lcd_out_byte   (lcd.out_byte),
    .lcd_is_command (lcd.is_command),
    .lcd_last       (lcd.last)
);
